// ----- rtl/aes128_cbc_block_cipher_defines.svh -----
// Assertion macros for the AES-128 CBC block.
`ifndef AES128_CBC_BLOCK_CIPHER_DEFINES_SVH
`define AES128_CBC_BLOCK_CIPHER_DEFINES_SVH
// implication checked on every clock edge outside reset
`define ACBC_ASSERT_IMPL(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ACBC_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- rtl/acbc_pkg.sv -----
// Shared types, constants and AES byte functions.
package acbc_pkg;
    localparam int ROUNDS = 10;
    localparam int NKEYS = ROUNDS + 1;
    localparam int RK_DEPTH = 2 * NKEYS;
    localparam int RK_AW = $clog2(RK_DEPTH);
    localparam int RND_W = $clog2(NKEYS + 1);
    localparam logic [2:0] REG_KEY_HIGH = 3'd0;
    localparam logic [2:0] REG_KEY_LOW = 3'd1;
    localparam logic [2:0] REG_IV_HIGH = 3'd2;
    localparam logic [2:0] REG_IV_LOW = 3'd3;
    localparam logic [2:0] REG_DECRYPT = 3'd4;
    localparam logic [7:0] POLY = 8'h1b;

    typedef logic [127:0] blk_t;

    function automatic logic [7:0] rcon(input logic [RND_W-1:0] i);
        logic [7:0] r;
        unique case (i)
            4'd1: r = 8'h01;
            4'd2: r = 8'h02;
            4'd3: r = 8'h04;
            4'd4: r = 8'h08;
            4'd5: r = 8'h10;
            4'd6: r = 8'h20;
            4'd7: r = 8'h40;
            4'd8: r = 8'h80;
            4'd9: r = 8'h1b;
            4'd10: r = 8'h36;
            default: r = 8'h8d;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? POLY : 8'h00);
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[x];
    endfunction

    // byte i of a block sits at bits 127-8i .. 120-8i
    function automatic logic [7:0] bget(input blk_t b, input int i);
        return b[127-8*i -: 8];
    endfunction

    function automatic blk_t enc_round(input blk_t b, input logic last);
        blk_t o;
        blk_t s;
        logic [7:0] a0, a1, a2, a3;
        o = '0;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                s[127-8*(4*c+r) -: 8] = sbox(bget(b, 4*((c+r)%4)+r));
        if (last) return s;
        for (int c = 0; c < 4; c++) begin
            a0 = bget(s, 4*c); a1 = bget(s, 4*c+1);
            a2 = bget(s, 4*c+2); a3 = bget(s, 4*c+3);
            o[127-8*(4*c) -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            o[127-8*(4*c+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
            o[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
            o[127-8*(4*c+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
        end
        return o;
    endfunction

    function automatic blk_t inv_sub_shift(input blk_t b);
        blk_t s;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                s[127-8*(4*c+r) -: 8] = inv_sbox(bget(b, 4*((c+4-r)%4)+r));
        return s;
    endfunction

    function automatic blk_t inv_mix(input blk_t b);
        blk_t o;
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                a[k] = bget(b, 4*c+k);
                x2[k] = xt(a[k]);
                x4[k] = xt(x2[k]);
                x8[k] = xt(x4[k]);
            end
            for (int r = 0; r < 4; r++)
                o[127-8*(4*c+r) -: 8] =
                    (x8[r] ^ x4[r] ^ x2[r]) ^
                    (x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4]) ^
                    (x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4]) ^
                    (x8[(r+3)%4] ^ a[(r+3)%4]);
        end
        return o;
    endfunction

    // next round key from the previous one
    function automatic blk_t key_step(input blk_t k, input logic [RND_W-1:0] ri);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        t = {sbox(w3[23:16]) ^ rcon(ri), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction
endpackage

// ----- rtl/aes128_cbc_block_cipher.sv -----
// AES-128 CBC top level: sequencer, round datapath and round key memory.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------
//  in        | in_valid / in_stall  | block_high, block_low, first_block
//  out       | out_valid / out_stall| result_high, result_low
//  cfg       | cfg_we               | cfg_index, cfg_data
//
// One round per cycle. Each 128-bit round key lives in an 11 x 64 RAM pair
// as high/low halves; both halves are read at once through two RAM instances.
// A word is loaded, runs its key reads for rounds 0 to 10 and finishes; a
// first word is preceded by key expansion (one round key per cycle).
// Reset clears control state and the key, IV and chain registers; round keys
// are undefined until the first word marked first_block. The finished result
// sits in an output register; a stalled output holds it and the next input
// waits only until that register is free.
`include "aes128_cbc_block_cipher_defines.svh"
module aes128_cbc_block_cipher
    import acbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    input  logic        first_block,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] result_high,
    output logic [63:0] result_low,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    typedef enum logic [1:0] {S_IDLE, S_EXPAND, S_ROUND, S_DONE} state_t;

    state_t           state_reg;
    blk_t             key_reg, iv_reg, chain_reg, data_reg, in_reg, kexp_reg;
    logic             dec_reg;
    logic [RND_W-1:0] rnd_reg;
    logic             out_valid_reg;
    blk_t             out_reg;
    logic             fwd_reg;

    // key RAMs: index 0..10 is the round; separate halves
    logic                 kwe;
    logic [RND_W-1:0]     kwaddr, kraddr;
    logic [63:0]          rk_hi, rk_lo;
    blk_t                 kwdata, rk, kexp_next, rk_use;

    acbc_ram #(.WIDTH(64), .DEPTH(NKEYS)) u_rk_hi (
        .clk(clk), .we(kwe), .waddr(kwaddr), .wdata(kwdata[127:64]),
        .raddr(kraddr), .rdata(rk_hi));
    acbc_ram #(.WIDTH(64), .DEPTH(NKEYS)) u_rk_lo (
        .clk(clk), .we(kwe), .waddr(kwaddr), .wdata(kwdata[63:0]),
        .raddr(kraddr), .rdata(rk_lo));
    assign rk = {rk_hi, rk_lo};

    // round key 10 is written in the same cycle a decrypt reads it;
    // take it straight from the expansion register then
    assign rk_use = fwd_reg ? kexp_reg : rk;

    logic accept;
    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign result_high = out_reg[127:64];
    assign result_low  = out_reg[63:0];

    assign kexp_next = key_step(kexp_reg, rnd_reg);

    // round index as seen by the RAM read issued this cycle
    always_comb
    begin
        kwe    = 1'b0;
        kwaddr = rnd_reg;
        kwdata = kexp_next;
        kraddr = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                kwe    = accept && first_block;
                kwaddr = '0;
                kwdata = key_reg;
                kraddr = dec_reg ? RND_W'(ROUNDS) : '0;
            end
            S_EXPAND:
            begin
                kwe    = 1'b1;
                kwaddr = rnd_reg;
                kraddr = dec_reg ? RND_W'(ROUNDS) : '0;
            end
            S_ROUND:
            begin
                // next read: round rnd_reg+1 (enc) or ROUNDS-rnd_reg-1 (dec)
                kraddr = dec_reg ? RND_W'(ROUNDS - 1) - rnd_reg : rnd_reg + 1'b1;
            end
            default:
            begin
                kraddr = '0;
            end
        endcase
    end

    // one step of the round datapath; rnd_reg counts key reads done
    blk_t step;
    always_comb
    begin
        if (rnd_reg == '0)
            step = data_reg ^ rk_use;
        else if (!dec_reg)
            step = enc_round(data_reg, rnd_reg == RND_W'(ROUNDS)) ^ rk_use;
        else if (rnd_reg == RND_W'(ROUNDS))
            step = inv_sub_shift(data_reg) ^ rk_use;
        else
            step = inv_mix(inv_sub_shift(data_reg) ^ rk_use);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            key_reg       <= '0;
            iv_reg        <= '0;
            chain_reg     <= '0;
            dec_reg       <= 1'b0;
            rnd_reg       <= '0;
            out_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_KEY_HIGH: key_reg[127:64] <= cfg_data;
                    REG_KEY_LOW:  key_reg[63:0]   <= cfg_data;
                    REG_IV_HIGH:  iv_reg[127:64]  <= cfg_data;
                    REG_IV_LOW:   iv_reg[63:0]    <= cfg_data;
                    REG_DECRYPT:  dec_reg         <= cfg_data[0];
                    default: ;
                endcase
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        in_reg <= {block_high, block_low};
                        if (first_block)
                        begin
                            kexp_reg <= key_reg;
                            rnd_reg  <= RND_W'(1);
                            state_reg <= S_EXPAND;
                            chain_reg <= iv_reg;
                            data_reg <= dec_reg ? {block_high, block_low}
                                                : {block_high, block_low} ^ iv_reg;
                        end
                        else
                        begin
                            rnd_reg  <= '0;
                            state_reg <= S_ROUND;
                            data_reg <= dec_reg ? {block_high, block_low}
                                                : {block_high, block_low} ^ chain_reg;
                        end
                    end
                end
                S_EXPAND:
                begin
                    kexp_reg <= kexp_next;
                    if (rnd_reg == RND_W'(ROUNDS))
                    begin
                        rnd_reg   <= '0;
                        fwd_reg   <= dec_reg;
                        state_reg <= S_ROUND;
                    end
                    else
                    begin
                        rnd_reg <= rnd_reg + 1'b1;
                    end
                end
                S_ROUND:
                begin
                    data_reg <= step;
                    fwd_reg  <= 1'b0;
                    if (rnd_reg == RND_W'(ROUNDS))
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        rnd_reg <= rnd_reg + 1'b1;
                    end
                end
                S_DONE:
                begin
                    // output register is free: in_stall held us out of IDLE otherwise
                    out_valid_reg <= 1'b1;
                    rnd_reg       <= '0;
                    state_reg     <= S_IDLE;
                    if (dec_reg)
                    begin
                        out_reg   <= data_reg ^ chain_reg;
                        chain_reg <= in_reg;
                    end
                    else
                    begin
                        out_reg   <= data_reg;
                        chain_reg <= data_reg;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `ACBC_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE, !accept,
        "input accepted while busy")
    `ACBC_ASSERT_NEXT(a_done_valid, clk, rst_n, state_reg == S_DONE, out_valid,
        "finished word not presented")
    `ACBC_ASSERT_IMPL(a_round_bound, clk, rst_n, state_reg != S_IDLE,
        rnd_reg <= RND_W'(ROUNDS), "round counter out of range")
endmodule

// ----- rtl/acbc_ram.sv -----
// Generic single-port-write, registered-read RAM.
module acbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- tb/tb_aes128_cbc_block_cipher.sv -----
// Testbench for the AES-128 CBC block cipher: self-checking, with random handshake idling.
`timescale 1ns / 100ps
module tb_aes128_cbc_block_cipher;
    import acbc_pkg::*;

    // Write indexes past the register list; the block must ignore them.
    localparam logic [2:0] REG_UNUSED_LO = 3'd5;
    localparam logic [2:0] REG_UNUSED_HI = 3'd7;
    localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
        logic        first;
    } cbc_word_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        first_block;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    aes128_cbc_block_cipher dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .block_high  (block_high),
        .block_low   (block_low),
        .first_block (first_block),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_high (result_high),
        .result_low  (result_low),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Words waiting to be driven, and cipher results still owed by the block.
    cbc_word_t    words_to_send[$];
    logic [127:0] owed_results[$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned words_queued;
    int unsigned mismatches;

    // Predictor state: shadow registers, chain value, round keys, S-boxes.
    logic [127:0] key_shadow;
    logic [127:0] iv_shadow;
    logic         decrypt_shadow;
    logic [127:0] chain_v;
    logic [127:0] round_key[11];
    logic [7:0]   fwd_box[256];
    logic [7:0]   rev_box[256];

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[0])
                p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            b = b >> 1;
        end
        return p;
    endfunction

    // S-box from the GF(2^8) inverse plus the affine map
    task automatic build_boxes();
        logic [7:0] inv;
        logic [7:0] s;
        for (int x = 0; x < 256; x++)
        begin
            inv = 8'h00;
            if (x != 0)
            begin
                inv = 8'h01;
                for (int k = 0; k < 254; k++)
                    inv = gf_mul(inv, x[7:0]);
            end
            s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
                ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            fwd_box[x] = s;
            rev_box[s] = x[7:0];
        end
    endtask

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {fwd_box[w[31:24]], fwd_box[w[23:16]], fwd_box[w[15:8]], fwd_box[w[7:0]]};
    endfunction

    function automatic void expand_round_keys();
        logic [31:0] w[44];
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        for (int i = 0; i < 4; i++)
            w[i] = key_shadow[127-32*i -: 32];
        for (int i = 4; i < 44; i++)
        begin
            t = w[i-1];
            if (i % 4 == 0)
            begin
                t = sub_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = gf_mul(rc, 8'h02);
            end
            w[i] = w[i-4] ^ t;
        end
        for (int j = 0; j < 11; j++)
            round_key[j] = {w[4*j], w[4*j+1], w[4*j+2], w[4*j+3]};
    endfunction

    // byte 4c+r is row r of column c; sub and shift commute
    function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
        logic [127:0] o;
        int src;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                src = inv ? (c + 4 - r) % 4 : (c + r) % 4;
                o[127-8*(4*c+r) -: 8] = inv ? rev_box[s[127-8*(4*src+r) -: 8]]
                                            : fwd_box[s[127-8*(4*src+r) -: 8]];
            end
        return o;
    endfunction

    function automatic logic [127:0] mix(input logic [127:0] s, input logic inv);
        logic [127:0] o;
        logic [7:0]   m[4];
        logic [7:0]   v;
        if (inv)
            m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        else
            m = '{8'h02, 8'h03, 8'h01, 8'h01};
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                v = 8'h00;
                for (int k = 0; k < 4; k++)
                    v ^= gf_mul(s[127-8*(4*c+k) -: 8], m[(k + 4 - r) % 4]);
                o[127-8*(4*c+r) -: 8] = v;
            end
        return o;
    endfunction

    // Expected result of one accepted word; advances the chain.
    function automatic logic [127:0] cbc_predict(input cbc_word_t w);
        logic [127:0] s;
        logic [127:0] res;
        if (w.first)
        begin
            expand_round_keys();
            chain_v = iv_shadow;
        end
        if (decrypt_shadow)
        begin
            s = {w.hi, w.lo} ^ round_key[10];
            for (int r = 9; r >= 0; r--)
            begin
                s = sub_shift(s, 1'b1) ^ round_key[r];
                if (r != 0)
                    s = mix(s, 1'b1);
            end
            res = s ^ chain_v;
            chain_v = {w.hi, w.lo};
        end
        else
        begin
            s = {w.hi, w.lo} ^ chain_v ^ round_key[0];
            for (int r = 1; r <= 10; r++)
            begin
                s = sub_shift(s, 1'b0);
                if (r != 10)
                    s = mix(s, 1'b0);
                s ^= round_key[r];
            end
            res = s;
            chain_v = s;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] MISMATCH %s", $realtime, what);
    endtask

    // Driver: predicts each word as it is taken, then offers the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                owed_results.push_back(cbc_predict('{block_high, block_low, first_block}));
            if (!in_valid || !in_stall)
            begin
                if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cbc_word_t w;
                    w = words_to_send.pop_front();
                    in_valid <= 1'b1;
                    block_high <= w.hi;
                    block_low <= w.lo;
                    first_block <= w.first;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each taken result against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (owed_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected word %h_%h", result_high, result_low));
                end
                else
                begin
                    logic [127:0] want;
                    want = owed_results.pop_front();
                    if (result_high !== want[127:64])
                        report_mismatch($sformatf("result_high %h want %h",
                                                  result_high, want[127:64]));
                    if (result_low !== want[63:0])
                        report_mismatch($sformatf("result_low %h want %h",
                                                  result_low, want[63:0]));
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_KEY_HIGH: key_shadow[127:64] = data;
            REG_KEY_LOW:  key_shadow[63:0] = data;
            REG_IV_HIGH:  iv_shadow[127:64] = data;
            REG_IV_LOW:   iv_shadow[63:0] = data;
            REG_DECRYPT:  decrypt_shadow = data[0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_word(input logic [63:0] hi, input logic [63:0] lo, input logic first);
        words_to_send.push_back('{hi, lo, first});
        words_queued++;
        // idling regime follows progress through the run
        if (words_queued < 330)
        begin
            send_idle_pct = 26;
            recv_idle_pct = 75;
        end
        else if (words_queued < 660)
        begin
            send_idle_pct = 75;
            recv_idle_pct = 26;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (words_to_send.size() != 0 || owed_results.size() != 0 || in_valid);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_value();
        case ($urandom_range(9))
            0: return 64'h0;
            1: return ALL_ONES;
            default: return rand64();
        endcase
    endfunction

    initial
    begin
        int unsigned len;
        rst_n = 1'b0;
        in_valid = 1'b0;
        block_high = '0;
        block_low = '0;
        first_block = 1'b0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_KEY_HIGH;
        cfg_data = '0;
        key_shadow = '0;
        iv_shadow = '0;
        decrypt_shadow = 1'b0;
        chain_v = '0;
        send_idle_pct = 26;
        recv_idle_pct = 75;
        words_queued = 0;
        mismatches = 0;
        build_boxes();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: all-zero key and IV, extreme blocks, encrypt.
        queue_word(64'h0, 64'h0, 1'b1);
        queue_word(ALL_ONES, ALL_ONES, 1'b0);
        queue_word(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
        wait_drained();

        // Known key/IV, all-ones extremes; bad index writes ignored.
        write_reg(REG_KEY_HIGH, 64'h2b7e151628aed2a6);
        write_reg(REG_KEY_LOW, 64'habf7158809cf4f3c);
        write_reg(REG_IV_HIGH, 64'h0001020304050607);
        write_reg(REG_IV_LOW, 64'h08090a0b0c0d0e0f);
        write_reg(REG_UNUSED_LO, ALL_ONES);
        write_reg(REG_UNUSED_HI, ALL_ONES);
        end_writes();
        queue_word(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 1'b1);
        queue_word(64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51, 1'b0);
        queue_word(ALL_ONES, 64'h0, 1'b0);
        wait_drained();

        // Mode switch mid-stream: chain continues in decrypt.
        write_reg(REG_DECRYPT, 64'h1);
        end_writes();
        queue_word(64'h7649abac8119b246, 64'hcee98e9b12e9197d, 1'b0);
        queue_word(64'h0, ALL_ONES, 1'b0);
        wait_drained();

        // Key/IV change without a first word keeps the old keys.
        write_reg(REG_KEY_HIGH, ALL_ONES);
        write_reg(REG_KEY_LOW, ALL_ONES);
        write_reg(REG_IV_HIGH, ALL_ONES);
        write_reg(REG_IV_LOW, ALL_ONES);
        end_writes();
        queue_word(64'h5086cb9b507219ee, 64'h95db113a917678b2, 1'b0);
        queue_word(ALL_ONES, ALL_ONES, 1'b1);
        queue_word(64'h0, 64'h0, 1'b0);
        wait_drained();

        // Back to encrypt; mode write with upper data bits set.
        write_reg(REG_DECRYPT, 64'hffff_ffff_ffff_fffe);
        end_writes();
        queue_word(ALL_ONES, ALL_ONES, 1'b1);
        queue_word(64'h8000000000000000, 64'h1, 1'b0);
        wait_drained();

        // Random buffers, with a new setting every phase.
        while (words_queued < 900)
        begin
            if ($urandom_range(3) != 0)
            begin
                write_reg(REG_KEY_HIGH, pick_value());
                write_reg(REG_KEY_LOW, pick_value());
            end
            if ($urandom_range(3) != 0)
            begin
                write_reg(REG_IV_HIGH, pick_value());
                write_reg(REG_IV_LOW, pick_value());
            end
            write_reg(REG_DECRYPT, {63'h0, 1'($urandom_range(1))});
            if ($urandom_range(7) == 0)
                write_reg(3'($urandom_range(REG_UNUSED_HI, REG_UNUSED_LO)), rand64());
            end_writes();
            repeat ($urandom_range(1, 4))
            begin
                // usually a fresh buffer, sometimes continuing the chain
                queue_word(pick_value(), pick_value(), $urandom_range(4) != 0);
                len = $urandom_range(1, 8);
                repeat (len)
                    queue_word(pick_value(), pick_value(), $urandom_range(19) == 0);
            end
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (mismatches == 0 && owed_results.size() == 0)
            $display("aes128_cbc_block_cipher: match");
        else
            $display("aes128_cbc_block_cipher: mismatch");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("aes128_cbc_block_cipher: mismatch");
        $finish;
    end
endmodule
